@@ rtl/core/pcs_pkg.sv @@
`default_nettype none
package pcs_pkg;

    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CENTER_X         = 3'd0,
        REG_CENTER_Y         = 3'd1,
        REG_CONTAINER_RADIUS = 3'd2,
        REG_PARTICLE_RADIUS  = 3'd3,
        REG_GRAVITY_X        = 3'd4,
        REG_GRAVITY_Y        = 3'd5
    } cfg_reg_t;

    localparam logic signed [31:0] CenterXReset         = 32'sd52428800;
    localparam logic signed [31:0] CenterYReset         = 32'sd29491200;
    localparam logic [30:0]        ContainerRadiusReset = 31'd26214400;
    localparam logic [30:0]        ParticleRadiusReset  = 31'd1310720;
    localparam logic signed [31:0] GravityXReset        = 32'sd0;
    localparam logic signed [31:0] GravityYReset        = 32'sd65536000;

    // Widths of the internal data path.
    localparam int SqW   = 66;  // sum of two 64-bit squares
    localparam int RootW = 33;  // floor(sqrt) of SqW bits
    localparam int NormW = 17;  // |normalized component| <= 65536
    localparam int DiffW = 35;  // signed overshoot
    localparam int QuoW  = 49;  // dividend |a| << 16

    // Root iterations per stage and stage count of the square root unit.
    localparam int SqrtPerStage = 3;
    localparam int SqrtStages   = 11;
    // Division bits per stage and stage count.
    localparam int DivPerStage  = 3;
    localparam int DivStages    = 6;

    // Saturate a wide signed value into 32 bits.
    function automatic logic [32:0] sat32(input logic signed [67:0] v);
        logic [32:0] r;
        if (v > 68'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -68'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/particle_container_step.sv @@
// Channel   | Direction | Ports                                 | Transfer
// ----------+-----------+---------------------------------------+------------------------
// s_        | in        | pos_x/y, vel_x/y, dt_step             | s_valid & s_ready
// m_        | out       | new_pos_x/y, new_vel_x/y, pushed, sat | m_valid & m_ready
// cfg_      | in        | cfg_index, cfg_data                   | cfg_valid & cfg_ready
//
// One particle enters per cycle while the output is not stalled.
// The pipeline depth comes from the pipelined square root (eleven stages of three root bits),
// followed by a six-stage restoring divider for the normalized axis and the product stages.
// A stall holds every stage at once; the last stage acts as the output register.
// Reset is synchronous; it clears only the valid bits and loads the configuration registers with their defaults.
`default_nettype none
module particle_container_step
    import pcs_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire signed [31:0] s_pos_x,
    input  wire signed [31:0] s_pos_y,
    input  wire signed [31:0] s_vel_x,
    input  wire signed [31:0] s_vel_y,
    input  wire        [15:0] s_dt_step,
    output logic              m_valid,
    input  wire               m_ready,
    output logic signed [31:0] m_new_pos_x,
    output logic signed [31:0] m_new_pos_y,
    output logic signed [31:0] m_new_vel_x,
    output logic signed [31:0] m_new_vel_y,
    output logic              m_pushed,
    output logic              m_saturated,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire [CfgIdxW-1:0] cfg_index,
    input  wire        [31:0] cfg_data
);

    localparam int Latency = 3 + SqrtStages + DivStages + 3;

    // Configuration registers.
    logic signed [31:0] center_x_reg, center_y_reg, gravity_x_reg, gravity_y_reg;
    logic [30:0] container_radius_reg, particle_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg         <= CenterXReset;
            center_y_reg         <= CenterYReset;
            container_radius_reg <= ContainerRadiusReset;
            particle_radius_reg  <= ParticleRadiusReset;
            gravity_x_reg        <= GravityXReset;
            gravity_y_reg        <= GravityYReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X:         center_x_reg         <= cfg_data;
                REG_CENTER_Y:         center_y_reg         <= cfg_data;
                REG_CONTAINER_RADIUS: container_radius_reg <= cfg_data[30:0];
                REG_PARTICLE_RADIUS:  particle_radius_reg  <= cfg_data[30:0];
                REG_GRAVITY_X:        gravity_x_reg        <= cfg_data;
                REG_GRAVITY_Y:        gravity_y_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances together.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic [Latency-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[Latency-2:0], s_valid};
        end
    end
    assign m_valid = vld_reg[Latency-1];

    // ---------------- Stage 1: axis, magnitudes ----------------
    logic signed [32:0] ax1_reg, ay1_reg;
    logic [32:0] max1_reg, may1_reg;
    logic [31:0] mvx1_reg, mvy1_reg;
    logic signed [31:0] px1_reg, py1_reg, vx1_reg, vy1_reg;
    logic [15:0] dt1_reg;
    logic signed [32:0] ax_w, ay_w;

    assign ax_w = 33'(center_x_reg) - 33'(s_pos_x);
    assign ay_w = 33'(center_y_reg) - 33'(s_pos_y);

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax1_reg  <= ax_w;
            ay1_reg  <= ay_w;
            max1_reg <= ax_w[32] ? 33'(-ax_w) : 33'(ax_w);
            may1_reg <= ay_w[32] ? 33'(-ay_w) : 33'(ay_w);
            mvx1_reg <= s_vel_x[31] ? 32'(-33'(s_vel_x)) : 32'(s_vel_x);
            mvy1_reg <= s_vel_y[31] ? 32'(-33'(s_vel_y)) : 32'(s_vel_y);
            px1_reg  <= s_pos_x;
            py1_reg  <= s_pos_y;
            vx1_reg  <= s_vel_x;
            vy1_reg  <= s_vel_y;
            dt1_reg  <= s_dt_step;
        end
    end

    // ---------------- Stage 2: squares, dt products ----------------
    logic [65:0] sqax2_reg, sqay2_reg;
    logic [63:0] sqvx2_reg, sqvy2_reg;
    logic signed [32:0] ax2_reg, ay2_reg;
    logic [32:0] max2_reg, may2_reg;
    logic signed [31:0] px2_reg, py2_reg, vx2_reg, vy2_reg;
    logic [15:0] dt2_reg;
    logic signed [32:0] dvx2_reg, dvy2_reg, dgx2_reg, dgy2_reg;

    function automatic logic signed [32:0] mul_dt(input logic signed [31:0] a,
                                                  input logic [15:0] dt);
        logic [31:0] m;
        logic [47:0] p;
        m = a[31] ? 32'(-33'(a)) : 32'(a);
        p = 48'(m) * 48'(dt);
        return a[31] ? -$signed({1'b0, p[47:16]}) : $signed({1'b0, p[47:16]});
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqax2_reg <= 66'(max1_reg) * 66'(max1_reg);
            sqay2_reg <= 66'(may1_reg) * 66'(may1_reg);
            sqvx2_reg <= 64'(mvx1_reg) * 64'(mvx1_reg);
            sqvy2_reg <= 64'(mvy1_reg) * 64'(mvy1_reg);
            dvx2_reg  <= mul_dt(vx1_reg, dt1_reg);
            dvy2_reg  <= mul_dt(vy1_reg, dt1_reg);
            dgx2_reg  <= mul_dt(gravity_x_reg, dt1_reg);
            dgy2_reg  <= mul_dt(gravity_y_reg, dt1_reg);
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            max2_reg  <= max1_reg;
            may2_reg  <= may1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            dt2_reg   <= dt1_reg;
        end
    end

    // ---------------- Stage 3: sums of squares ----------------
    typedef struct packed {
        logic signed [32:0] ax, ay;
        logic [32:0] max, may;
        logic signed [31:0] px, py, vx, vy;
        logic [15:0] dt;
        logic signed [32:0] dvx, dvy, dgx, dgy;
    } carry_t;

    logic [SqW-1:0] ssa3_reg, ssv3_reg;
    carry_t c3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ssa3_reg <= sqax2_reg + sqay2_reg;
            ssv3_reg <= 66'(sqvx2_reg) + 66'(sqvy2_reg);
            c3_reg   <= '{ax: ax2_reg, ay: ay2_reg, max: max2_reg, may: may2_reg,
                          px: px2_reg, py: py2_reg, vx: vx2_reg, vy: vy2_reg,
                          dt: dt2_reg, dvx: dvx2_reg, dvy: dvy2_reg,
                          dgx: dgx2_reg, dgy: dgy2_reg};
        end
    end

    // ---------------- Square root pipeline (two roots in parallel) ----------------
    typedef struct packed {
        logic [SqW-1:0]   rad;
        logic [RootW+1:0] rem;
        logic [RootW-1:0] root;
    } sqrt_t;

    function automatic sqrt_t sqrt_steps(input sqrt_t s, input int base);
        sqrt_t r;
        logic [RootW+1:0] trial, rm;
        logic [1:0] pair;
        r = s;
        for (int k = 0; k < SqrtPerStage; k++) begin
            if (base + k < RootW) begin
                pair  = r.rad[SqW-1 -: 2];
                r.rad = {r.rad[SqW-3:0], 2'b00};
                rm    = {r.rem[RootW-1:0], pair};
                trial = {r.root, 2'b01};
                if (rm >= trial) begin
                    r.rem  = rm - trial;
                    r.root = {r.root[RootW-2:0], 1'b1};
                end else begin
                    r.rem  = rm;
                    r.root = {r.root[RootW-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

    sqrt_t sa_reg [1:SqrtStages];
    sqrt_t sv_reg [1:SqrtStages];
    carry_t cs_reg [1:SqrtStages];
    sqrt_t sa_in_w, sv_in_w;

    assign sa_in_w = '{rad: ssa3_reg, rem: '0, root: '0};
    assign sv_in_w = '{rad: ssv3_reg, rem: '0, root: '0};

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg[1] <= sqrt_steps(sa_in_w, 0);
            sv_reg[1] <= sqrt_steps(sv_in_w, 0);
            cs_reg[1] <= c3_reg;
            for (int g = 1; g < SqrtStages; g++) begin
                sa_reg[g+1] <= sqrt_steps(sa_reg[g], g * SqrtPerStage);
                sv_reg[g+1] <= sqrt_steps(sv_reg[g], g * SqrtPerStage);
                cs_reg[g+1] <= cs_reg[g];
            end
        end
    end

    logic [RootW-1:0] alen_w, vlen_w;
    assign alen_w = sa_reg[SqrtStages].root;
    assign vlen_w = sv_reg[SqrtStages].root;

    // ---------------- Stage D0: step length and overshoot ----------------
    logic [48:0] step_w;
    logic signed [DiffW-1:0] diff_w;
    assign step_w = 49'(vlen_w) * 49'(cs_reg[SqrtStages].dt);
    assign diff_w = DiffW'(alen_w) + DiffW'(particle_radius_reg)
                  + DiffW'(step_w[48:16]) - DiffW'(container_radius_reg);

    // ---------------- Divider pipeline: |a| << 16 / alen, both axes ----------------
    typedef struct packed {
        logic [QuoW-1:0]  num;   // shifts out dividend, shifts in quotient
        logic [RootW:0]   rem;
    } div_t;

    typedef struct packed {
        carry_t c;
        logic [RootW-1:0] len;
        logic signed [DiffW-1:0] diff;
    } dcarry_t;

    localparam int DivBits = NormW;  // quotient never exceeds 2^16

    function automatic div_t div_steps(input div_t s, input logic [RootW-1:0] d,
                                       input int base);
        div_t r;
        logic [RootW:0] rm;
        r = s;
        for (int k = 0; k < DivPerStage; k++) begin
            if (base + k < DivBits) begin
                rm    = {r.rem[RootW-1:0], r.num[QuoW-1]};
                r.num = {r.num[QuoW-2:0], 1'b0};
                if (rm >= {1'b0, d}) begin
                    r.rem = rm - {1'b0, d};
                    r.num[0] = 1'b1;
                end else begin
                    r.rem = rm;
                end
            end
        end
        return r;
    endfunction

    // The top 32 dividend bits are preloaded as a partial remainder; |a| < 2^33 and
    // the quotient fits 17 bits, so only the last 17 bits need restoring steps.
    div_t dx_reg [1:DivStages];
    div_t dy_reg [1:DivStages];
    dcarry_t dc_reg [1:DivStages];
    div_t dx_in_w, dy_in_w;
    dcarry_t dc_in_w;

    assign dx_in_w = '{num: {cs_reg[SqrtStages].max[0], 48'd0},
                       rem: {2'b00, cs_reg[SqrtStages].max[32:1]}};
    assign dy_in_w = '{num: {cs_reg[SqrtStages].may[0], 48'd0},
                       rem: {2'b00, cs_reg[SqrtStages].may[32:1]}};
    assign dc_in_w = '{c: cs_reg[SqrtStages], len: alen_w, diff: diff_w};

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg[1] <= div_steps(dx_in_w, alen_w, 0);
            dy_reg[1] <= div_steps(dy_in_w, alen_w, 0);
            dc_reg[1] <= dc_in_w;
            for (int g = 1; g < DivStages; g++) begin
                dx_reg[g+1] <= div_steps(dx_reg[g], dc_reg[g].len, g * DivPerStage);
                dy_reg[g+1] <= div_steps(dy_reg[g], dc_reg[g].len, g * DivPerStage);
                dc_reg[g+1] <= dc_reg[g];
            end
        end
    end

    // ---------------- Stage P1: push products ----------------
    dcarry_t p1c_reg;
    logic [51:0] pmx_reg, pmy_reg;
    logic [NormW-1:0] nx_w, ny_w;
    logic [DiffW-2:0] dpos_w;

    assign nx_w   = (dc_reg[DivStages].len == '0) ? '0 : dx_reg[DivStages].num[NormW-1:0];
    assign ny_w   = (dc_reg[DivStages].len == '0) ? '0 : dy_reg[DivStages].num[NormW-1:0];
    assign dpos_w = dc_reg[DivStages].diff[DiffW-2:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1c_reg <= dc_reg[DivStages];
            pmx_reg <= 52'(nx_w) * 52'(dpos_w);
            pmy_reg <= 52'(ny_w) * 52'(dpos_w);
        end
    end

    // ---------------- Stage P2: sums ----------------
    logic signed [67:0] sx_w, sy_w, svx_w, svy_w, mvx_w, mvy_w;
    logic push_w;
    assign push_w = !p1c_reg.diff[DiffW-1] && (p1c_reg.diff != '0);
    assign mvx_w  = !push_w ? 68'sd0 :
                    (p1c_reg.c.ax[32] ? -$signed(68'(pmx_reg[51:16]))
                                      :  $signed(68'(pmx_reg[51:16])));
    assign mvy_w  = !push_w ? 68'sd0 :
                    (p1c_reg.c.ay[32] ? -$signed(68'(pmy_reg[51:16]))
                                      :  $signed(68'(pmy_reg[51:16])));
    assign sx_w   = 68'(p1c_reg.c.px) + mvx_w + 68'(p1c_reg.c.dvx);
    assign sy_w   = 68'(p1c_reg.c.py) + mvy_w + 68'(p1c_reg.c.dvy);
    assign svx_w  = 68'(p1c_reg.c.vx) + 68'(p1c_reg.c.dgx);
    assign svy_w  = 68'(p1c_reg.c.vy) + 68'(p1c_reg.c.dgy);

    logic [32:0] opx_reg, opy_reg, ovx_reg, ovy_reg;
    logic push2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            opx_reg   <= sat32(sx_w);
            opy_reg   <= sat32(sy_w);
            ovx_reg   <= sat32(svx_w);
            ovy_reg   <= sat32(svy_w);
            push2_reg <= push_w;
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_new_pos_x <= opx_reg[31:0];
            m_new_pos_y <= opy_reg[31:0];
            m_new_vel_x <= ovx_reg[31:0];
            m_new_vel_y <= ovy_reg[31:0];
            m_pushed    <= push2_reg;
            m_saturated <= opx_reg[32] | opy_reg[32] | ovx_reg[32] | ovy_reg[32];
        end
    end

    // A stalled result must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_pos_x) && $stable(m_pushed))
        else $error("result changed while stalled");

    // Input is refused only while a result is stalled.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // An accepted request must be captured in the first valid stage.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request lost in first stage");

endmodule
`default_nettype wire
